@@ rtl/m4vt_pkg.sv @@
// Shared types and constants of the 4x4 matrix-vector transform core.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package m4vt_pkg;

   // Field widths of the channels and matrix geometry
   localparam int DATA_W  = 32;
   localparam int OPC_W   = 3;
   localparam int IDX_W   = 4;
   localparam int ROWS    = 4;
   localparam int COLS    = 4;
   localparam int ELEMS   = ROWS * COLS;
   localparam int ROW_W   = $clog2(ROWS);
   localparam int Q_DEPTH = 2;

   // Opcodes on the request channel
   localparam logic [OPC_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OPC_W-1:0] OP_VEC4   = 3'd1;
   localparam logic [OPC_W-1:0] OP_POINT  = 3'd2;
   localparam logic [OPC_W-1:0] OP_MULCOL = 3'd3;
   localparam logic [OPC_W-1:0] OP_COMMIT = 3'd4;

   // Decoded command kinds carried through the queue
   typedef enum logic [2:0] {
      CMD_LOAD   = 3'd0,
      CMD_VEC4   = 3'd1,
      CMD_POINT  = 3'd2,
      CMD_MULCOL = 3'd3,
      CMD_COMMIT = 3'd4
   } cmd_kind_type;

   // One queued command; operands already sign-extended from the word width
   typedef struct packed {
      cmd_kind_type                     kind;
      logic [IDX_W-1:0]                 index;
      logic [DATA_W-1:0]                value;
      logic [COLS-1:0][DATA_W-1:0]      vec;
   } cmd_type;

   // Queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/m4vt_req_if.sv @@
// Request channel of the transform core: valid/ready plus opcode and operands.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps

interface m4vt_req_if;
   import m4vt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OPC_W-1:0]         opcode;
   logic [IDX_W-1:0]         element_index;
   logic signed [DATA_W-1:0] element_value;
   logic signed [DATA_W-1:0] vec_x;
   logic signed [DATA_W-1:0] vec_y;
   logic signed [DATA_W-1:0] vec_z;
   logic signed [DATA_W-1:0] vec_w;

   modport source (output valid, output opcode, output element_index, output element_value,
                   output vec_x, output vec_y, output vec_z, output vec_w, input ready);
   modport sink   (input valid, input opcode, input element_index, input element_value,
                   input vec_x, input vec_y, input vec_z, input vec_w, output ready);
endinterface

@@ rtl/m4vt_rsp_if.sv @@
// Response channel of the transform core: valid/ready plus four components and flag.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps

interface m4vt_rsp_if;
   import m4vt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_x;
   logic signed [DATA_W-1:0] out_y;
   logic signed [DATA_W-1:0] out_z;
   logic signed [DATA_W-1:0] out_w;
   logic                     saturated;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                   input saturated, output ready);
endinterface

@@ rtl/m4vt_queue.sv @@
// Short command queue between the decode front and the execute back.
// Depends on m4vt_pkg (cmd_type, queue_status_type, Q_DEPTH).
`timescale 1ns / 1ps

module m4vt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  m4vt_pkg::cmd_type         push_data,
   input  logic                      pop,
   output m4vt_pkg::cmd_type         pop_data,
   output m4vt_pkg::queue_status_type status
);
   import m4vt_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   cmd_type          entry_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ rtl/m4vt_front.sv @@
// Decode front: accepts request beats, drops unused opcodes, narrows operands.
// Depends on m4vt_pkg and m4vt_req_if.
`timescale 1ns / 1ps

module m4vt_front #(
   parameter int WORD_WIDTH = 32
) (
   m4vt_req_if.sink                   req,
   input  m4vt_pkg::queue_status_type q_status,
   output logic                       push,
   output m4vt_pkg::cmd_type          push_data
);
   import m4vt_pkg::*;

   localparam int W = WORD_WIDTH;

   logic         known;
   cmd_kind_type kind;

   // Take a beat whenever the queue has room
   assign req.ready = !q_status.full;

   // Classify the opcode
   always_comb begin
      known = 1'b1;
      kind  = CMD_LOAD;
      unique case (req.opcode)
         OP_LOAD:   kind = CMD_LOAD;
         OP_VEC4:   kind = CMD_VEC4;
         OP_POINT:  kind = CMD_POINT;
         OP_MULCOL: kind = CMD_MULCOL;
         OP_COMMIT: kind = CMD_COMMIT;
         default:   known = 1'b0;
      endcase
   end

   // Keep the low word of each operand, sign-extended
   always_comb begin
      push_data.kind   = kind;
      push_data.index  = req.element_index;
      push_data.value  = DATA_W'($signed(req.element_value[W-1:0]));
      push_data.vec[0] = DATA_W'($signed(req.vec_x[W-1:0]));
      push_data.vec[1] = DATA_W'($signed(req.vec_y[W-1:0]));
      push_data.vec[2] = DATA_W'($signed(req.vec_z[W-1:0]));
      push_data.vec[3] = DATA_W'($signed(req.vec_w[W-1:0]));
   end

   assign push = req.valid && req.ready && known;

endmodule

@@ rtl/m4vt_back.sv @@
// Execute back: matrix and pending stores, 16 parallel multipliers, sum/shift/saturate
// stage and the response register. Depends on m4vt_pkg and m4vt_rsp_if.
`timescale 1ns / 1ps

module m4vt_back #(
   parameter int FRAC_BITS  = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  m4vt_pkg::cmd_type          head,
   input  m4vt_pkg::queue_status_type q_status,
   output logic                       pop,
   m4vt_rsp_if.source                 rsp
);
   import m4vt_pkg::*;

   localparam int W      = WORD_WIDTH;
   localparam int PROD_W = 2 * W;
   localparam int PT_W   = W + FRAC_BITS + 1;
   localparam int SUM_W  = ((PROD_W > PT_W) ? PROD_W : PT_W) + 2;
   localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0]     mat_ff  [ELEMS];
   logic signed [W-1:0]     mat_in  [ELEMS];
   logic signed [W-1:0]     pend_ff [ELEMS];
   logic signed [W-1:0]     pend_in [ELEMS];
   logic signed [W-1:0]     head_vec [COLS];

   logic                    s1_valid_ff, s1_valid_in;
   cmd_kind_type            s1_kind_ff;
   logic [ROW_W-1:0]        s1_col_ff;
   logic signed [SUM_W-1:0] s1_term_ff [ROWS][COLS];
   logic signed [SUM_W-1:0] s1_term_in [ROWS][COLS];

   logic                    s2_valid_ff, s2_valid_in;
   logic [DATA_W-1:0]       s2_out_ff [ROWS];
   logic [DATA_W-1:0]       s2_out_in [ROWS];
   logic                    s2_sat_ff, s2_sat_in;

   logic signed [W-1:0]     row_res [ROWS];
   logic [ROWS-1:0]         row_sat;

   logic head_avail, s1_adv, s1_free, do_load, do_commit, do_compute;

   // Issue control: loads and commits act at pop, compute ops enter stage 1
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp.ready);
   assign s1_free    = !s1_valid_ff || s1_adv;
   assign head_avail = !q_status.empty;

   always_comb begin
      pop = 1'b0;
      unique case (head.kind)
         CMD_LOAD:   pop = head_avail;
         // hold a commit until a column product in flight has reached the pending store
         CMD_COMMIT: pop = head_avail && !(s1_valid_ff && s1_kind_ff == CMD_MULCOL);
         CMD_VEC4,
         CMD_POINT,
         CMD_MULCOL: pop = head_avail && s1_free;
         default:    pop = 1'b0;
      endcase
   end

   assign do_load    = pop && (head.kind == CMD_LOAD);
   assign do_commit  = pop && (head.kind == CMD_COMMIT);
   assign do_compute = pop && (head.kind == CMD_VEC4 || head.kind == CMD_POINT
                               || head.kind == CMD_MULCOL);

   // Matrix store: single element load or full copy from the pending store
   always_comb begin
      mat_in = mat_ff;
      if (do_load) begin
         mat_in[head.index] = head.value[W-1:0];
      end else if (do_commit) begin
         mat_in = pend_ff;
      end
   end

   // Pending store: write back one column as it leaves stage 1
   always_comb begin
      pend_in = pend_ff;
      if (s1_adv && s1_kind_ff == CMD_MULCOL) begin
         for (int r = 0; r < ROWS; r++) begin
            pend_in[{s1_col_ff, ROW_W'(r)}] = row_res[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEMS; i++) begin
            mat_ff[i]  <= '0;
            pend_ff[i] <= '0;
         end
      end else begin
         mat_ff  <= mat_in;
         pend_ff <= pend_in;
      end
   end

   // Stage 1: sixteen products, the w column replaced by a shift for points
   for (genvar e = 0; e < COLS; e++) begin : g_vec
      assign head_vec[e] = head.vec[e][W-1:0];
   end

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar e = 0; e < COLS; e++) begin : g_col
         logic signed [PROD_W-1:0] prod;
         assign prod = mat_ff[r + ROWS * e] * head_vec[e];
         if (e == COLS - 1) begin : g_w
            logic signed [SUM_W-1:0] unit_term;
            assign unit_term = SUM_W'(mat_ff[r + ROWS * e]) <<< FRAC_BITS;
            assign s1_term_in[r][e] = (head.kind == CMD_POINT) ? unit_term : SUM_W'(prod);
         end else begin : g_xyz
            assign s1_term_in[r][e] = SUM_W'(prod);
         end
      end
   end

   assign s1_valid_in = do_compute || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_compute) begin
         s1_kind_ff <= head.kind;
         s1_col_ff  <= head.index[ROW_W-1:0];
         s1_term_ff <= s1_term_in;
      end
   end

   // Stage 2: sum four terms, drop the fraction bits, clamp to the word range
   for (genvar r = 0; r < ROWS; r++) begin : g_sum
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] shifted;
      logic                    fits;
      assign sum     = s1_term_ff[r][0] + s1_term_ff[r][1] + s1_term_ff[r][2]
                     + s1_term_ff[r][3];
      assign shifted = sum >>> FRAC_BITS;
      assign fits    = (shifted[SUM_W-1:W-1] == '0) || (shifted[SUM_W-1:W-1] == '1);
      assign row_res[r] = fits ? shifted[W-1:0] : (shifted[SUM_W-1] ? WORD_MIN : WORD_MAX);
      assign row_sat[r] = !fits;
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         s2_out_in[r] = DATA_W'(row_res[r]);
      end
      s2_sat_in = |row_sat;
      // points report three components and a zero w
      if (s1_kind_ff == CMD_POINT) begin
         s2_out_in[ROWS-1] = '0;
         s2_sat_in         = |row_sat[ROWS-2:0];
      end
   end

   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_out_ff <= s2_out_in;
         s2_sat_ff <= s2_sat_in;
      end
   end

   // Drive the response beat
   assign rsp.valid     = s2_valid_ff;
   assign rsp.out_x     = s2_out_ff[0];
   assign rsp.out_y     = s2_out_ff[1];
   assign rsp.out_z     = s2_out_ff[2];
   assign rsp.out_w     = s2_out_ff[3];
   assign rsp.saturated = s2_sat_ff;

endmodule

@@ rtl/matrix4_vector_transform_core.sv @@
// 4x4 Q-format matrix-vector transform core. A result beat passes the queue, the
// multiply stage and the sum/clamp stage after its request beat is accepted.
// Throughput: one beat per cycle while responses are taken; a commit right behind a
// column multiply waits until that column has reached the pending store.
// Reset (synchronous, active high) clears the matrix and pending stores, the queue and
// both pipeline stages; the core accepts beats in the first cycle after reset.
`timescale 1ns / 1ps

module matrix4_vector_transform_core #(
   parameter int FRAC_BITS  = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   m4vt_req_if.sink    req_ch,
   m4vt_rsp_if.source  rsp_ch
);
   import m4vt_pkg::*;

   logic             q_push;
   logic             q_pop;
   cmd_type          q_push_data;
   cmd_type          q_pop_data;
   queue_status_type q_status;

   // Decode front
   m4vt_front #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_front (
      .req       (req_ch),
      .q_status  (q_status),
      .push      (q_push),
      .push_data (q_push_data)
   );

   // Command queue
   m4vt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Execute back
   m4vt_back #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_WIDTH(WORD_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_pop_data),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp      (rsp_ch)
   );

   // Queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("command queue overflow");

   // Queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("command queue underflow");

   // Unused opcodes are dropped at the front
   a_drop_unused: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.opcode != OP_LOAD && req_ch.opcode != OP_VEC4
       && req_ch.opcode != OP_POINT && req_ch.opcode != OP_MULCOL
       && req_ch.opcode != OP_COMMIT) |-> !q_push)
      else $error("unused opcode entered the queue");

   // No response beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

endmodule
